/* rtl/core/cdn_pkg.sv */
// Types, constants and calendar helper functions shared by the day-number unit.
package cdn_pkg;

    localparam logic [11:0] EPOCH_YEAR        = 12'd1900;
    localparam logic [11:0] TOP_YEAR          = 12'd4095;
    localparam logic [10:0] RECIP_100         = 11'd1311;
    localparam logic [10:0] DAYS_PER_YEAR     = 11'd365;
    localparam logic [8:0]  LEAPS_PRE_EPOCH   = 9'd460;
    localparam logic [3:0]  LAST_MONTH        = 4'd12;
    localparam logic [3:0]  MARCH             = 4'd3;
    localparam logic [4:0]  OVF_DAY           = 5'd31;
    localparam logic [3:0]  OVF_MONTH         = 4'd12;

    localparam logic [1:0] ACT_DAY_NUM = 2'd0;
    localparam logic [1:0] ACT_DIFF    = 2'd1;
    localparam logic [1:0] ACT_ADD     = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  first_day;
        logic [3:0]  first_month;
        logic [11:0] first_year;
        logic [4:0]  second_day;
        logic [3:0]  second_month;
        logic [11:0] second_year;
        logic [11:0] add_days;
    } t_req;

    typedef struct packed {
        logic signed [20:0] day_count;
        logic [4:0]         result_day;
        logic [3:0]         result_month;
        logic [11:0]        result_year;
        logic               overflow;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL100, ST_MUL400, ST_MUL365, ST_REM, ST_Y4,
        ST_Q100, ST_Q400, ST_EPOCH, ST_MON, ST_STEP, ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_MUL100, OP_MUL400, OP_MUL365, OP_REM, OP_Y4,
        OP_Q100, OP_Q400, OP_EPOCH, OP_MON, OP_STEP
    } t_op;

    typedef struct packed {
        t_op  op;
        logic second;
        logic emit;
    } t_ctrl;

    typedef struct packed {
        logic       step_done;
        logic [1:0] action;
    } t_stat;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            default: len = 5'd30;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            4'd13:   d = 9'd365;
            4'd14:   d = 9'd395;
            4'd15:   d = 9'd425;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

/* rtl/core/cdn_stream_if.sv */
// Valid/ready stream interface carrying one payload beat.
interface cdn_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/calendar_day_number_unit.sv */
// Top level of the Gregorian day-number unit (epoch 1900-01-01 is day 1).
//
// Request channel i_req carries one beat per request: an action code, a
// first date, a second date and a count of days to add. Response channel
// o_rsp returns exactly one beat per request, in request order.
// Action 0 returns the day number of the first date, action 1 the first
// date's day number minus the second's, action 2 the first date moved on by
// add_days; action 3 returns an all-zero beat.
// Action 1 runs the day-number steps once for each date; action 2 walks on
// month by month, a final partial month included. One shared 12x11
// multiplier and one accumulator do all year arithmetic, and the month walk
// takes one month per cycle, so the unit works on one request at a time and
// i_req.ready is low meanwhile.
// A finished beat sits in an output register; the next request is taken
// while it waits. If the receiver stalls, the unit holds the beat, then
// holds its next result until the register frees.
// Reset returns the sequencer to idle and empties the output register.
module calendar_day_number_unit
    import cdn_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    cdn_stream_if.sink    i_req,
    cdn_stream_if.source  o_rsp
);

    t_ctrl ctrl;
    t_stat stat;
    t_rsp  res;
    logic  ready;
    logic  out_free;
    logic  r_rsp_valid;
    t_rsp  r_rsp;

    assign out_free = !r_rsp_valid || o_rsp.ready;

    cdn_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_req.valid),
        .i_action   (i_req.payload.action),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_ready    (ready),
        .o_ctrl     (ctrl)
    );

    cdn_date_unit u_date (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .i_req  (i_req.payload),
        .o_stat (stat),
        .o_res  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (ctrl.emit) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit) begin
            r_rsp <= res;
        end
    end

    assign i_req.ready   = ready;
    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

endmodule

/* rtl/core/cdn_date_unit.sv */
// Shared datapath: multiplier, accumulator, year counters and month stepper.
module cdn_date_unit
    import cdn_pkg::*;
(
    input  logic  i_clk,
    input  t_ctrl i_ctrl,
    input  t_req  i_req,
    output t_stat o_stat,
    output t_rsp  o_res
);

    t_req               r_req;
    logic [22:0]        r_prod;
    logic [5:0]         r_q100;
    logic [3:0]         r_q400;
    logic [6:0]         r_r100;
    logic [8:0]         r_r400;
    logic [20:0]        r_acc;
    logic [4:0]         r_day;
    logic [3:0]         r_mon;
    logic [11:0]        r_yr;
    logic signed [13:0] r_k;
    logic               r_ov;

    logic [4:0]         sel_day;
    logic [3:0]         sel_mon;
    logic [11:0]        sel_year;
    logic [11:0]        mul_a;
    logic [10:0]        mul_b;
    logic [22:0]        prod;
    logic               leap;
    logic               past_epoch;
    logic [4:0]         mlen;
    logic [20:0]        addend;
    logic               sub;
    logic               acc_en;
    logic [20:0]        n_acc;
    logic [11:0]        hund;
    logic [11:0]        four_hund;
    logic signed [14:0] day_s;
    logic signed [14:0] k_s;
    logic signed [14:0] len_s;
    logic signed [14:0] sum_s;
    logic signed [14:0] hop_s;
    logic signed [14:0] k_rem;
    logic               k_done;

    assign sel_day  = i_ctrl.second ? r_req.second_day   : r_req.first_day;
    assign sel_mon  = i_ctrl.second ? r_req.second_month : r_req.first_month;
    assign sel_year = i_ctrl.second ? r_req.second_year  : r_req.first_year;

    always_comb begin
        case (i_ctrl.op)
            OP_MUL100: begin
                mul_a = sel_year;
                mul_b = RECIP_100;
            end
            OP_MUL400: begin
                mul_a = {2'b00, r_yr[11:2]};
                mul_b = RECIP_100;
            end
            OP_MUL365: begin
                mul_a = r_yr - EPOCH_YEAR;
                mul_b = DAYS_PER_YEAR;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = 23'(mul_a) * 23'(mul_b);

    assign leap       = (r_yr[1:0] == 2'd0) && ((r_r100 != 7'd0) || (r_r400 == 9'd0));
    assign past_epoch = r_yr > EPOCH_YEAR;
    assign mlen       = month_len(r_mon, leap);
    assign hund       = 12'(r_q100) * 12'd100;
    assign four_hund  = 12'(r_q400) * 12'd400;

    always_comb begin
        addend = '0;
        sub    = 1'b0;
        acc_en = 1'b1;
        case (i_ctrl.op)
            OP_MUL100: addend = 21'(sel_day);
            OP_REM:    addend = past_epoch ? r_prod[20:0] : '0;
            OP_Y4:     addend = past_epoch ? 21'(r_yr[11:2]) : '0;
            OP_Q100: begin
                addend = past_epoch ? 21'(r_q100) : '0;
                sub    = 1'b1;
            end
            OP_Q400:   addend = past_epoch ? 21'(r_q400) : '0;
            OP_EPOCH: begin
                addend = past_epoch ? 21'(LEAPS_PRE_EPOCH) + 21'(leap) : '0;
                sub    = 1'b1;
            end
            OP_MON: addend = 21'(days_before(r_mon)) + 21'(leap && (r_mon >= MARCH));
            default: acc_en = 1'b0;
        endcase
        n_acc = (sub ^ i_ctrl.second) ? r_acc - addend : r_acc + addend;
    end

    assign day_s  = {10'b0, r_day};
    assign k_s    = {r_k[13], r_k};
    assign len_s  = {10'b0, mlen};
    assign sum_s  = k_s + day_s;
    assign hop_s  = len_s - day_s + 15'sd1;
    assign k_rem  = k_s - hop_s;
    assign k_done = r_k[13] || (r_k == 14'sd0);

    always_ff @(posedge i_clk) begin
        if (acc_en) begin
            r_acc <= n_acc;
        end
        case (i_ctrl.op)
            OP_LOAD: begin
                r_req <= i_req;
                r_acc <= '0;
                r_k   <= $signed({2'b00, i_req.add_days});
                r_ov  <= 1'b0;
            end
            OP_MUL100: begin
                r_prod <= prod;
                r_yr   <= sel_year;
                r_mon  <= sel_mon;
                r_day  <= sel_day;
            end
            OP_MUL400: begin
                r_q100 <= r_prod[22:17];
                r_prod <= prod;
            end
            OP_MUL365: begin
                r_q400 <= r_prod[20:17];
                r_prod <= prod;
            end
            OP_REM: begin
                r_r100 <= 7'(r_yr - hund);
                r_r400 <= 9'(r_yr - four_hund);
            end
            OP_STEP: begin
                if (sum_s > len_s) begin
                    r_k   <= k_rem[13:0];
                    r_day <= 5'd1;
                    if (r_mon >= LAST_MONTH) begin
                        r_mon <= 4'd1;
                        if (r_yr == TOP_YEAR) begin
                            r_ov <= 1'b1;
                        end else begin
                            r_yr   <= r_yr + 12'd1;
                            r_r100 <= (r_r100 == 7'd99)  ? 7'd0 : r_r100 + 7'd1;
                            r_r400 <= (r_r400 == 9'd399) ? 9'd0 : r_r400 + 9'd1;
                        end
                    end else begin
                        r_mon <= r_mon + 4'd1;
                    end
                end else begin
                    r_day <= sum_s[4:0];
                    r_k   <= '0;
                end
            end
            default: ;
        endcase
    end

    assign o_stat.step_done = k_done || r_ov;
    assign o_stat.action    = r_req.action;

    always_comb begin
        o_res = '0;
        case (r_req.action)
            ACT_DAY_NUM, ACT_DIFF: o_res.day_count = $signed(r_acc);
            ACT_ADD: begin
                if (r_ov) begin
                    o_res.result_day   = OVF_DAY;
                    o_res.result_month = OVF_MONTH;
                    o_res.result_year  = TOP_YEAR;
                    o_res.overflow     = 1'b1;
                end else begin
                    o_res.result_day   = r_day;
                    o_res.result_month = r_mon;
                    o_res.result_year  = r_yr;
                end
            end
            default: o_res = '0;
        endcase
    end

endmodule

/* rtl/core/cdn_seq.sv */
// Sequencer stepping the shared datapath through one request.
module cdn_seq
    import cdn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_action,
    input  logic       i_out_free,
    input  t_stat      i_stat,
    output logic       o_ready,
    output t_ctrl      o_ctrl
);

    t_state r_state;
    t_state n_state;
    logic   r_second;
    logic   n_second;
    logic   accept;

    assign accept = i_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        case (r_state)
            ST_IDLE: begin
                n_second = 1'b0;
                if (accept) begin
                    if ((i_action == ACT_DAY_NUM) || (i_action == ACT_DIFF) ||
                        (i_action == ACT_ADD)) begin
                        n_state = ST_MUL100;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_MUL100: n_state = ST_MUL400;
            ST_MUL400: n_state = ST_MUL365;
            ST_MUL365: n_state = ST_REM;
            ST_REM:    n_state = (i_stat.action == ACT_ADD) ? ST_STEP : ST_Y4;
            ST_Y4:     n_state = ST_Q100;
            ST_Q100:   n_state = ST_Q400;
            ST_Q400:   n_state = ST_EPOCH;
            ST_EPOCH:  n_state = ST_MON;
            ST_MON: begin
                if ((i_stat.action == ACT_DIFF) && !r_second) begin
                    n_second = 1'b1;
                    n_state  = ST_MUL100;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_STEP: begin
                if (i_stat.step_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready       = (r_state == ST_IDLE);
        o_ctrl.second = r_second;
        o_ctrl.emit   = 1'b0;
        case (r_state)
            ST_IDLE:   o_ctrl.op = accept ? OP_LOAD : OP_NONE;
            ST_MUL100: o_ctrl.op = OP_MUL100;
            ST_MUL400: o_ctrl.op = OP_MUL400;
            ST_MUL365: o_ctrl.op = OP_MUL365;
            ST_REM:    o_ctrl.op = OP_REM;
            ST_Y4:     o_ctrl.op = OP_Y4;
            ST_Q100:   o_ctrl.op = OP_Q100;
            ST_Q400:   o_ctrl.op = OP_Q400;
            ST_EPOCH:  o_ctrl.op = OP_EPOCH;
            ST_MON:    o_ctrl.op = OP_MON;
            ST_STEP:   o_ctrl.op = i_stat.step_done ? OP_NONE : OP_STEP;
            ST_OUT: begin
                o_ctrl.op   = OP_NONE;
                o_ctrl.emit = i_out_free;
            end
            default:   o_ctrl.op = OP_NONE;
        endcase
    end

endmodule

/* rtl/core/cdn_checker.sv */
// Port-level checks for the day-number unit, bound to the top level.
module cdn_checker
    import cdn_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp
);

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while a request is in progress");

    a_no_instant_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !$rose(i_rsp_valid))
        else $error("response beat appeared too soon after a request");

    a_ovf_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp.overflow) |->
        (i_rsp.result_year == TOP_YEAR && i_rsp.result_month == OVF_MONTH &&
         i_rsp.result_day == OVF_DAY && i_rsp.day_count == 21'sd0))
        else $error("overflow beat not clamped to the last day");

    a_count_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp.day_count != 21'sd0) |->
        (i_rsp.result_day == 5'd0 && i_rsp.result_month == 4'd0 &&
         i_rsp.result_year == 12'd0 && !i_rsp.overflow))
        else $error("day count beat carries date fields");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp)))
        else $error("stalled response beat changed");

endmodule

bind calendar_day_number_unit cdn_checker u_cdn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.payload)
);
